FILE: design/qrs_pkg.sv
// shared types, widths and helpers for the quadratic root solver
package qrs_pkg;

  // number format
  localparam int WORD_BITS = 32;
  localparam int FRAC_BITS = 16;
  localparam int EPS_W     = 16;
  localparam logic [EPS_W-1:0] EPS_RESET = EPS_W'(7);

  // square root chain: discriminant is below 2^(2W+1), root below 2^(W+1)
  localparam int ROOT_W   = WORD_BITS + 1;
  localparam int RAD_W    = 2 * ROOT_W;
  localparam int SQ_REM_W = ROOT_W + 2;
  localparam int SQ_STEPS = ROOT_W;

  // divider chain: numerator magnitude below 2^(W+2), divisor up to 2^W
  localparam int NUM_W     = WORD_BITS + 2;
  localparam int DVD_W     = NUM_W + FRAC_BITS;
  localparam int DEN_W     = WORD_BITS + 1;
  localparam int DIV_STEPS = DVD_W;

  typedef enum logic [1:0] {
    CNT_NONE = 2'd0,
    CNT_ONE  = 2'd1,
    CNT_TWO  = 2'd2,
    CNT_INF  = 2'd3
  } count_e;

  // one square root step state
  typedef struct packed {
    logic [SQ_REM_W-1:0] rem;
    logic [ROOT_W-1:0]   root;
    logic [RAD_W-1:0]    rad;
  } sq_t;

  // one divider step state: rq holds remaining dividend bits and quotient bits
  typedef struct packed {
    logic [DEN_W-1:0] rem;
    logic [DVD_W-1:0] rq;
    logic [DEN_W-1:0] den;
  } dv_t;

  // sideband carried alongside the square root chain
  typedef struct packed {
    logic [WORD_BITS-1:0] b;
    logic [WORD_BITS-1:0] am;
    logic [WORD_BITS-1:0] bm;
    logic [WORD_BITS-1:0] cm;
    logic                 a_neg;
    logic                 lin;
    logic                 lin_neg;
    logic                 bm_gt;
    logic                 cm_le;
    logic                 have;
  } sq_side_t;

  // sideband carried alongside the divider chain
  typedef struct packed {
    logic lin;
    logic bm_gt;
    logic cm_le;
    logic have;
    logic neg1;
    logic neg2;
  } dv_side_t;

  // one finished result
  typedef struct packed {
    count_e               count;
    logic [WORD_BITS-1:0] r1;
    logic [WORD_BITS-1:0] r2;
    logic                 ovf;
  } res_t;

  // magnitude of a two's complement word
  function automatic logic [WORD_BITS-1:0] mag_f(input logic [WORD_BITS-1:0] v);
    mag_f = v[WORD_BITS-1] ? (~v + 1'b1) : v;
  endfunction

endpackage

FILE: design/qrs_coef_if.sv
// coefficient channel: valid/ready plus a, b, c
interface qrs_coef_if import qrs_pkg::*; ();
  logic                        valid;
  logic                        ready;
  logic signed [WORD_BITS-1:0] coef_a;
  logic signed [WORD_BITS-1:0] coef_b;
  logic signed [WORD_BITS-1:0] coef_c;

  modport source (output valid, coef_a, coef_b, coef_c, input ready);
  modport sink   (input valid, coef_a, coef_b, coef_c, output ready);
endinterface

FILE: design/qrs_root_if.sv
// result channel: valid/ready plus root count, roots and overflow
interface qrs_root_if import qrs_pkg::*; ();
  logic                        valid;
  logic                        ready;
  logic [1:0]                  root_count;
  logic signed [WORD_BITS-1:0] root_first;
  logic signed [WORD_BITS-1:0] root_second;
  logic                        overflow;

  modport source (output valid, root_count, root_first, root_second, overflow, input ready);
  modport sink   (input valid, root_count, root_first, root_second, overflow, output ready);
endinterface

FILE: design/quadratic_root_solver.sv
// Quadratic root solver, a pipeline from coefficient beat to result valid.
// Accepts one equation per cycle unless the output buffer is full; the depth is set by the 33-cell
// square root chain and the 50-cell divider chains, one step per cell.
// A two-entry output buffer takes results; the whole pipeline stalls only when it is full.
// Reset (async, active low) clears all valid bits and sets epsilon to 7; no clearing pass.
module quadratic_root_solver import qrs_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             epsilon_we_i,
  input  logic [EPS_W-1:0] epsilon_i,
  qrs_coef_if.sink         coef_in,
  qrs_root_if.source       root_out
);

  localparam int W = WORD_BITS;

  logic [EPS_W-1:0] eps_q;
  logic [W-1:0]     eps_ext;
  logic             en;
  logic [1:0]       ob_cnt_q;

  // epsilon register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) eps_q <= EPS_RESET;
    else if (epsilon_we_i) eps_q <= epsilon_i;
  end
  assign eps_ext = {{(W-EPS_W){1'b0}}, eps_q};

  // pipeline advances unless the output buffer is full
  assign en            = (ob_cnt_q != 2'd2);
  assign coef_in.ready = en;

  // valid bits
  logic                 v0_q, v1_q, v2_q, v3_q, vs_q;
  logic [SQ_STEPS-1:0]  sqv_q;
  logic [DIV_STEPS-1:0] dvv_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q  <= 1'b0;
      v1_q  <= 1'b0;
      v2_q  <= 1'b0;
      sqv_q <= '0;
      v3_q  <= 1'b0;
      dvv_q <= '0;
      vs_q  <= 1'b0;
    end else if (en) begin
      v0_q  <= coef_in.valid;
      v1_q  <= v0_q;
      v2_q  <= v1_q;
      sqv_q <= {sqv_q[SQ_STEPS-2:0], v2_q};
      v3_q  <= sqv_q[SQ_STEPS-1];
      dvv_q <= {dvv_q[DIV_STEPS-2:0], v3_q};
      vs_q  <= dvv_q[DIV_STEPS-1];
    end
  end

  // stage 0: capture coefficients
  logic [W-1:0] a0_q, b0_q, c0_q;
  always_ff @(posedge clk_i) begin
    if (en) begin
      a0_q <= coef_in.coef_a;
      b0_q <= coef_in.coef_b;
      c0_q <= coef_in.coef_c;
    end
  end

  // stage 1: magnitudes and products b*b, a*c
  logic [W-1:0]   am0, bm0, cm0;
  logic [2*W-1:0] bb1_q, ac1_q;
  logic [W-1:0]   b1_q, am1_q, bm1_q, cm1_q;
  logic           an1_q, bn1_q, cn1_q;

  assign am0 = mag_f(a0_q);
  assign bm0 = mag_f(b0_q);
  assign cm0 = mag_f(c0_q);

  always_ff @(posedge clk_i) begin
    if (en) begin
      bb1_q <= bm0 * bm0;
      ac1_q <= am0 * cm0;
      b1_q  <= b0_q;
      am1_q <= am0;
      bm1_q <= bm0;
      cm1_q <= cm0;
      an1_q <= a0_q[W-1];
      bn1_q <= b0_q[W-1];
      cn1_q <= c0_q[W-1];
    end
  end

  // stage 2: discriminant and linear-case tests
  logic [RAD_W-1:0] bb_ext, ac4;
  logic             ac_neg;
  sq_t              sq2_d, sq2_q;
  sq_side_t         side2_d, side2_q;

  always_comb begin
    bb_ext = {2'b00, bb1_q};
    ac4    = {ac1_q, 2'b00};
    ac_neg = an1_q ^ cn1_q;
    sq2_d.rem  = '0;
    sq2_d.root = '0;
    sq2_d.rad  = ac_neg ? (bb_ext + ac4) : (bb_ext - ac4);
    side2_d.b       = b1_q;
    side2_d.am      = am1_q;
    side2_d.bm      = bm1_q;
    side2_d.cm      = cm1_q;
    side2_d.a_neg   = an1_q;
    side2_d.lin     = (am1_q <= eps_ext);
    side2_d.lin_neg = (cn1_q == bn1_q);
    side2_d.bm_gt   = (bm1_q > eps_ext);
    side2_d.cm_le   = (cm1_q <= eps_ext);
    side2_d.have    = ac_neg || (ac4 <= bb_ext);
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      sq2_q   <= sq2_d;
      side2_q <= side2_d;
    end
  end

  // square root chain
  sq_t      sq_c [SQ_STEPS+1];
  sq_side_t sside_q [SQ_STEPS];

  assign sq_c[0] = sq2_q;

  for (genvar k = 0; k < SQ_STEPS; k++) begin : g_sq
    qrs_sqrt_cell u_sq (
      .clk_i (clk_i),
      .en_i  (en),
      .d_i   (sq_c[k]),
      .q_o   (sq_c[k+1])
    );
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      sside_q[0] <= side2_q;
      for (int k = 1; k < SQ_STEPS; k++) sside_q[k] <= sside_q[k-1];
    end
  end

  // stage 3: numerators -b +/- sqrt(D), divider set-up
  sq_side_t     s3;
  logic [NUM_W:0]   bx, sx, n1, n2;
  logic [NUM_W-1:0] m1, m2, num1;
  dv_t          dv1_d, dv2_d, dv1_q, dv2_q;
  dv_side_t     dside3_d, dside3_q;

  always_comb begin
    s3   = sside_q[SQ_STEPS-1];
    bx   = {{(NUM_W+1-W){s3.b[W-1]}}, s3.b};
    sx   = {{(NUM_W+1-ROOT_W){1'b0}}, sq_c[SQ_STEPS].root};
    n1   = sx - bx;
    n2   = (NUM_W+1)'(0) - bx - sx;
    m1   = n1[NUM_W] ? NUM_W'(~n1 + 1'b1) : n1[NUM_W-1:0];
    m2   = n2[NUM_W] ? NUM_W'(~n2 + 1'b1) : n2[NUM_W-1:0];
    num1 = s3.lin ? {{(NUM_W-W){1'b0}}, s3.cm} : m1;
    dv1_d.rem = '0;
    dv1_d.rq  = {num1, {FRAC_BITS{1'b0}}};
    dv1_d.den = s3.lin ? {1'b0, s3.bm} : {s3.am, 1'b0};
    dv2_d.rem = '0;
    dv2_d.rq  = {m2, {FRAC_BITS{1'b0}}};
    dv2_d.den = {s3.am, 1'b0};
    dside3_d.lin   = s3.lin;
    dside3_d.bm_gt = s3.bm_gt;
    dside3_d.cm_le = s3.cm_le;
    dside3_d.have  = s3.have;
    dside3_d.neg1  = s3.lin ? s3.lin_neg : (n1[NUM_W] ^ s3.a_neg);
    dside3_d.neg2  = n2[NUM_W] ^ s3.a_neg;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      dv1_q    <= dv1_d;
      dv2_q    <= dv2_d;
      dside3_q <= dside3_d;
    end
  end

  // two divider chains
  dv_t      dv1_c [DIV_STEPS+1];
  dv_t      dv2_c [DIV_STEPS+1];
  dv_side_t dside_q [DIV_STEPS];

  assign dv1_c[0] = dv1_q;
  assign dv2_c[0] = dv2_q;

  for (genvar k = 0; k < DIV_STEPS; k++) begin : g_dv
    qrs_div_cell u_dv1 (
      .clk_i (clk_i),
      .en_i  (en),
      .d_i   (dv1_c[k]),
      .q_o   (dv1_c[k+1])
    );
    qrs_div_cell u_dv2 (
      .clk_i (clk_i),
      .en_i  (en),
      .d_i   (dv2_c[k]),
      .q_o   (dv2_c[k+1])
    );
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      dside_q[0] <= dside3_q;
      for (int k = 1; k < DIV_STEPS; k++) dside_q[k] <= dside_q[k-1];
    end
  end

  // saturating sign application: returns {ovf, root}
  function automatic logic [W:0] sat_f(input logic [DVD_W-1:0] q, input logic neg);
    logic [DVD_W-1:0] lim;
    lim = DVD_W'(1) << (W-1);
    if (neg) begin
      if (q > lim) sat_f = {1'b1, 1'b1, {(W-1){1'b0}}};
      else         sat_f = {1'b0, W'(~q[W-1:0] + 1'b1)};
    end else begin
      if (q > lim - 1'b1) sat_f = {1'b1, 1'b0, {(W-1){1'b1}}};
      else                sat_f = {1'b0, q[W-1:0]};
    end
  endfunction

  // saturation stage
  logic [W-1:0] r1s_q, r2s_q;
  logic         o1s_q, o2s_q;
  dv_side_t     dsides_q;
  logic [W:0]   sat1, sat2;

  assign sat1 = sat_f(dv1_c[DIV_STEPS].rq, dside_q[DIV_STEPS-1].neg1);
  assign sat2 = sat_f(dv2_c[DIV_STEPS].rq, dside_q[DIV_STEPS-1].neg2);

  always_ff @(posedge clk_i) begin
    if (en) begin
      r1s_q    <= sat1[W-1:0];
      o1s_q    <= sat1[W];
      r2s_q    <= sat2[W-1:0];
      o2s_q    <= sat2[W];
      dsides_q <= dside_q[DIV_STEPS-1];
    end
  end

  // final decision: count, unused roots and overflow
  logic [W:0] diff, dmag;
  logic       close;
  res_t       res;

  always_comb begin
    diff  = {r1s_q[W-1], r1s_q} - {r2s_q[W-1], r2s_q};
    dmag  = diff[W] ? (~diff + 1'b1) : diff;
    close = (dmag <= {1'b0, eps_ext});
    res.count = CNT_NONE;
    res.r1    = '0;
    res.r2    = '0;
    res.ovf   = 1'b0;
    if (dsides_q.lin) begin
      if (dsides_q.bm_gt) begin
        res.count = CNT_ONE;
        res.r1    = r1s_q;
        res.ovf   = o1s_q;
      end else begin
        res.count = dsides_q.cm_le ? CNT_INF : CNT_NONE;
      end
    end else if (dsides_q.have) begin
      if (close) begin
        res.count = CNT_ONE;
        res.r1    = r1s_q;
        res.ovf   = o1s_q;
      end else begin
        res.count = CNT_TWO;
        res.r1    = r1s_q;
        res.r2    = r2s_q;
        res.ovf   = o1s_q | o2s_q;
      end
    end
  end

  // two-entry output buffer
  logic push, pop;
  res_t ob0_q, ob1_q;

  assign push = en && vs_q;
  assign pop  = root_out.valid && root_out.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) ob_cnt_q <= 2'd0;
    else ob_cnt_q <= ob_cnt_q + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk_i) begin
    unique case (ob_cnt_q)
      2'd0: begin
        if (push) ob0_q <= res;
      end
      2'd1: begin
        if (push && pop) ob0_q <= res;
        else if (push)   ob1_q <= res;
      end
      2'd2: begin
        if (pop) ob0_q <= ob1_q;
      end
      default: begin
        ob0_q <= ob0_q;
      end
    endcase
  end

  assign root_out.valid       = (ob_cnt_q != 2'd0);
  assign root_out.root_count  = ob0_q.count;
  assign root_out.root_first  = ob0_q.r1;
  assign root_out.root_second = ob0_q.r2;
  assign root_out.overflow    = ob0_q.ovf;

`ifndef SYNTHESIS
  a_buf_cnt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ob_cnt_q != 2'd3)
    else $error("output buffer count out of range");

  a_stall_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !coef_in.ready |-> root_out.valid)
    else $error("input stalled with no result waiting");

  a_no_roots: assert property (@(posedge clk_i) disable iff (!rst_ni)
    root_out.valid && (root_out.root_count == CNT_NONE || root_out.root_count == CNT_INF)
    |-> !root_out.overflow && root_out.root_first == '0 && root_out.root_second == '0)
    else $error("unused roots or overflow set without reported roots");

  a_second: assert property (@(posedge clk_i) disable iff (!rst_ni)
    root_out.valid && root_out.root_count != CNT_TWO |-> root_out.root_second == '0)
    else $error("second root set without two roots");
`endif

endmodule

FILE: design/qrs_sqrt_cell.sv
// one digit-by-digit square root step, registered
module qrs_sqrt_cell import qrs_pkg::*; (
  input  logic clk_i,
  input  logic en_i,
  input  sq_t  d_i,
  output sq_t  q_o
);

  logic [SQ_REM_W+1:0] cur;
  logic [SQ_REM_W+1:0] trial;
  logic                take;
  sq_t                 cell_d;
  sq_t                 cell_q;

  // bring down two radicand bits, try root*4+1
  always_comb begin
    cur    = {d_i.rem, d_i.rad[RAD_W-1 -: 2]};
    trial  = {{(SQ_REM_W-ROOT_W){1'b0}}, d_i.root, 2'b01};
    take   = (cur >= trial);
    cell_d.rem  = take ? SQ_REM_W'(cur - trial) : cur[SQ_REM_W-1:0];
    cell_d.root = {d_i.root[ROOT_W-2:0], take};
    cell_d.rad  = {d_i.rad[RAD_W-3:0], 2'b00};
  end

  always_ff @(posedge clk_i) begin
    if (en_i) cell_q <= cell_d;
  end

  assign q_o = cell_q;

endmodule

FILE: design/qrs_div_cell.sv
// one restoring division step, registered
module qrs_div_cell import qrs_pkg::*; (
  input  logic clk_i,
  input  logic en_i,
  input  dv_t  d_i,
  output dv_t  q_o
);

  logic [DEN_W:0] cur;
  logic           take;
  dv_t            cell_d;
  dv_t            cell_q;

  // shift in the next dividend bit, subtract divisor when it fits
  always_comb begin
    cur  = {d_i.rem, d_i.rq[DVD_W-1]};
    take = (cur >= {1'b0, d_i.den});
    cell_d.rem = take ? DEN_W'(cur - {1'b0, d_i.den}) : cur[DEN_W-1:0];
    cell_d.rq  = {d_i.rq[DVD_W-2:0], take};
    cell_d.den = d_i.den;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) cell_q <= cell_d;
  end

  assign q_o = cell_q;

endmodule
